// ----- sv/olirs_pkg.sv -----
`default_nettype none

package olirs_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_REMOVE
    } t_shift_op;

    typedef struct packed {
        t_shift_op op;        // applied in the cycle a request is accepted
        logic      scan_read; // scan wave looks for a position, not a value
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- sv/olirs_cell.sv -----
`default_nettype none

module olirs_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7,
    parameter int VW  = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  olirs_pkg::t_cell_ctrl i_ctrl,
    input  wire  [CW-1:0]        i_shift_pos,
    input  wire  [CW-1:0]        i_scan_pos,
    input  wire  [CW-1:0]        i_count,
    input  wire  [VW-1:0]        i_ins_val,
    input  wire  [VW-1:0]        i_key,
    input  wire  [VW-1:0]        i_left,
    input  wire  [VW-1:0]        i_right,
    output logic [VW-1:0]        o_value,
    input  wire                  i_c_vld,
    input  wire                  i_c_hit,
    input  wire  [IW-1:0]        i_c_idx,
    input  wire  [VW-1:0]        i_c_val,
    output logic                 o_c_vld,
    output logic                 o_c_hit,
    output logic [IW-1:0]        o_c_idx,
    output logic [VW-1:0]        o_c_val
);
    import olirs_pkg::*;

    localparam logic [CW-1:0] K = CW'(IDX);

    logic [VW-1:0] r_value;
    logic [VW-1:0] n_value;
    logic          my_hit;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            SH_INSERT: begin
                if (K == i_shift_pos) begin
                    n_value = i_ins_val;
                end else if (K > i_shift_pos) begin
                    n_value = i_left;
                end
            end
            SH_REMOVE: begin
                if (K >= i_shift_pos) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    assign my_hit = (K < i_count) &&
                    (i_ctrl.scan_read ? (K == i_scan_pos) : (r_value == i_key));

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            o_c_vld <= 1'b0;
        end else begin
            o_c_vld <= i_c_vld;
        end
        if (i_c_vld) begin
            o_c_hit <= i_c_hit || my_hit;
            // earlier cell already hit: the first hit wins
            if (!i_c_hit && my_hit) begin
                o_c_idx <= IW'(IDX);
                o_c_val <= r_value;
            end else begin
                o_c_idx <= i_c_idx;
                o_c_val <= i_c_val;
            end
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- sv/ordered_list_insert_remove_search.sv -----
`default_nettype none

// Channel   Dir  Handshake               Payload
// s_axis    in   i_s_tvalid/o_s_tready   command, position, item_value
// m_axis    out  o_m_tvalid/i_m_tready   status, found_position, read_value, list_length
//
// Clear, insert, remove and rejected requests: the result is registered at the
// accepting edge, so with a free output one such request is taken every cycle.
// Search and in-range read send a wave through the row of CAPACITY cells, one cell
// per cycle: the wave starts from r_start, its result is caught in the r_res registers,
// and S_EMIT moves it to the output once free; only then is the next request taken.
// Synchronous active-low reset empties the list; stored values are not cleared.
// While a result waits on a stalled output, one more request is taken and held;
// the input then stalls until the waiting result leaves.

module ordered_list_insert_remove_search #(
    parameter int CAPACITY    = olirs_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = olirs_pkg::VALUE_WIDTH_DEF,
    localparam int IW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int FW      = IW + 1,
    localparam int IN_BITS = olirs_pkg::CMD_W + CW + VALUE_WIDTH,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = olirs_pkg::STATUS_W + FW + VALUE_WIDTH + CW,
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    input  wire  [IN_W-1:0]  i_s_tdata,   // command, position, item_value
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // status, found_position, read_value, list_length
);
    import olirs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state r_state;

    logic [CMD_W-1:0]       in_cmd;
    logic [CW-1:0]          in_pos;
    logic [VALUE_WIDTH-1:0] in_val;

    assign in_cmd = i_s_tdata[0 +: CMD_W];
    assign in_pos = i_s_tdata[CMD_W +: CW];
    assign in_val = i_s_tdata[CMD_W + CW +: VALUE_WIDTH];

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [CW-1:0]          r_scan_pos;
    logic                   r_scan_read;
    logic                   r_start;

    logic [STATUS_W-1:0]    r_out_status, r_res_status, imm_status, scan_status;
    logic [FW-1:0]          r_out_found, r_res_found, scan_found;
    logic [VALUE_WIDTH-1:0] r_out_read, r_res_read, scan_read_val;
    logic [CW-1:0]          r_out_len, r_res_len;
    logic                   r_out_valid;

    logic       accept, out_free, full, ins_ok, rem_ok, rd_ok, scan_go;
    t_cell_ctrl ctrl;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign full       = (r_count == CW'(CAPACITY));

    always_comb begin
        ins_ok     = 1'b0;
        rem_ok     = 1'b0;
        rd_ok      = 1'b0;
        scan_go    = 1'b0;
        imm_status = ST_OK;
        n_count    = r_count;
        unique case (in_cmd)
            CMD_CLEAR: n_count = '0;
            CMD_INSERT: begin
                if (full) begin
                    imm_status = ST_FULL;
                end else if (in_pos > r_count) begin
                    imm_status = ST_RANGE;
                end else begin
                    ins_ok  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (in_pos < r_count) begin
                    rem_ok  = 1'b1;
                    n_count = r_count - CW'(1);
                end else begin
                    imm_status = ST_RANGE;
                end
            end
            CMD_SEARCH: scan_go = 1'b1;
            CMD_READ: begin
                if (in_pos < r_count) begin
                    rd_ok   = 1'b1;
                    scan_go = 1'b1;
                end else begin
                    imm_status = ST_RANGE;
                end
            end
            default: n_count = r_count;
        endcase
    end

    always_comb begin
        ctrl.op        = SH_HOLD;
        ctrl.scan_read = r_scan_read;
        if (accept && ins_ok) begin
            ctrl.op = SH_INSERT;
        end else if (accept && rem_ok) begin
            ctrl.op = SH_REMOVE;
        end
    end

    // row of cells with the scan wave running from cell 0 upward
    logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
    logic                   c_vld [CAPACITY+1];
    logic                   c_hit [CAPACITY+1];
    logic [IW-1:0]          c_idx [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] c_val [CAPACITY+1];

    assign c_vld[0] = r_start;
    assign c_hit[0] = 1'b0;
    assign c_idx[0] = '0;
    assign c_val[0] = '0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_val, right_val;
        if (k == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[k+1];
        end

        olirs_cell #(
            .IDX (k),
            .IW  (IW),
            .CW  (CW),
            .VW  (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_shift_pos (in_pos),
            .i_scan_pos  (r_scan_pos),
            .i_count     (r_count),
            .i_ins_val   (in_val),
            .i_key       (r_key),
            .i_left      (left_val),
            .i_right     (right_val),
            .o_value     (cell_val[k]),
            .i_c_vld     (c_vld[k]),
            .i_c_hit     (c_hit[k]),
            .i_c_idx     (c_idx[k]),
            .i_c_val     (c_val[k]),
            .o_c_vld     (c_vld[k+1]),
            .o_c_hit     (c_hit[k+1]),
            .o_c_idx     (c_idx[k+1]),
            .o_c_val     (c_val[k+1])
        );
    end

    always_comb begin
        if (r_scan_read) begin
            scan_status   = ST_OK;
            scan_found    = '0;
            scan_read_val = c_val[CAPACITY];
        end else if (c_hit[CAPACITY]) begin
            scan_status   = ST_OK;
            scan_found    = FW'(c_idx[CAPACITY]);
            scan_read_val = '0;
        end else begin
            scan_status   = ST_MISSING;
            scan_found    = '1;
            scan_read_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_start     <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count <= n_count;
                        if (scan_go) begin
                            r_key       <= in_val;
                            r_scan_pos  <= in_pos;
                            r_scan_read <= rd_ok;
                            r_start     <= 1'b1;
                            r_state     <= S_SCAN;
                        end else if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= imm_status;
                            r_out_found  <= '0;
                            r_out_read   <= '0;
                            r_out_len    <= n_count;
                        end else begin
                            r_res_status <= imm_status;
                            r_res_found  <= '0;
                            r_res_read   <= '0;
                            r_res_len    <= n_count;
                            r_state      <= S_EMIT;
                        end
                    end
                end
                S_SCAN: begin
                    if (c_vld[CAPACITY]) begin
                        r_res_status <= scan_status;
                        r_res_found  <= scan_found;
                        r_res_read   <= scan_read_val;
                        r_res_len    <= r_count;
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_found  <= r_res_found;
                        r_out_read   <= r_res_read;
                        r_out_len    <= r_res_len;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_len, r_out_read, r_out_found, r_out_status});

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list length above capacity");

    a_scan_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |=> (r_state != S_SCAN || $stable(r_count)))
        else $error("list length changed during a scan");

    a_wave_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_start || c_vld[CAPACITY]) |-> r_state == S_SCAN)
        else $error("scan wave outside of scan state");

    a_miss_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_MISSING) |-> r_out_found == '1)
        else $error("search miss without -1 position");

endmodule

`default_nettype wire

// ----- tb/list_checker.sv -----
`timescale 1ns / 100ps

module list_checker #(
    parameter int CAP   = olirs_pkg::CAPACITY_DEF,
    parameter int VAL_W = olirs_pkg::VALUE_WIDTH_DEF,
    parameter int IN_W  = 48,
    parameter int OUT_W = 48
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_s_tvalid,
    input  wire             i_s_tready,
    input  wire [IN_W-1:0]  i_s_tdata,   // command, position, item_value
    input  wire             i_m_tvalid,
    input  wire             i_m_tready,
    input  wire [OUT_W-1:0] i_m_tdata,   // status, found_position, read_value, list_length
    output int              o_mismatches,
    output int              o_pending
);
    import olirs_pkg::*;

    localparam int POS_W   = $clog2(CAP + 1);
    localparam int FOUND_W = $clog2(CAP) + 1;
    localparam int REQ_BITS = CMD_W + POS_W + VAL_W;
    localparam int RES_BITS = STATUS_W + FOUND_W + VAL_W + POS_W;
    localparam int MAX_REPORTS = 10;

    // field order mirrors the bus packing, lowest field last
    typedef struct packed {
        logic [VAL_W-1:0] item_value;
        logic [POS_W-1:0] position;
        logic [CMD_W-1:0] command;
    } t_list_request;

    typedef struct packed {
        logic [POS_W-1:0]    length;
        logic [VAL_W-1:0]    read_value;
        logic [FOUND_W-1:0]  found_pos;
        logic [STATUS_W-1:0] status;
    } t_list_result;

    logic [VAL_W-1:0] list_vals [CAP];
    int               list_len;
    t_list_result     expected_results [$];
    int               n_results;

    t_list_request req;
    t_list_result  got;
    t_list_result  exp_res;

    initial begin
        list_len     = 0;
        n_results    = 0;
        o_mismatches = 0;
        o_pending    = 0;
    end

    // Applies one request to the shadow list and returns what the block should answer.
    function automatic t_list_result apply_list_request(input t_list_request rq);
        t_list_result res;
        int           k;
        bit           hit;
        res = '0;
        case (rq.command)
            CMD_CLEAR: begin
                list_len = 0;
            end
            CMD_INSERT: begin
                if (list_len >= CAP) begin
                    res.status = ST_FULL;
                end else if (rq.position > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = list_len; k > rq.position; k--)
                        list_vals[k] = list_vals[k-1];
                    list_vals[rq.position] = rq.item_value;
                    list_len++;
                end
            end
            CMD_REMOVE: begin
                if (rq.position >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = rq.position; k + 1 < list_len; k++)
                        list_vals[k] = list_vals[k+1];
                    list_len--;
                end
            end
            CMD_SEARCH: begin
                hit = 1'b0;
                for (k = 0; k < list_len; k++) begin
                    if (!hit && list_vals[k] == rq.item_value) begin
                        hit           = 1'b1;
                        res.found_pos = k[FOUND_W-1:0];
                    end
                end
                if (!hit) begin
                    res.status    = ST_MISSING;
                    res.found_pos = '1;
                end
            end
            CMD_READ: begin
                if (rq.position >= list_len)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_vals[rq.position];
            end
            default: ;  // unused codes leave the list alone
        endcase
        res.length = list_len[POS_W-1:0];
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input t_list_result e,
                                          input t_list_result g);
        o_mismatches++;
        if (o_mismatches <= MAX_REPORTS) begin
            $write("%s, result %0d: expected st=%0d pos=%0d val=%h len=%0d",
                   what, n_results, e.status, $signed(e.found_pos), e.read_value, e.length);
            $display(", got st=%0d pos=%0d val=%h len=%0d",
                     g.status, $signed(g.found_pos), g.read_value, g.length);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // results first: a result never belongs to a request taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                got = t_list_result'(i_m_tdata[RES_BITS-1:0]);
                if (expected_results.size() == 0) begin
                    note_mismatch("Unexpected result", '0, got);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.status !== exp_res.status || got.found_pos !== exp_res.found_pos ||
                        got.read_value !== exp_res.read_value || got.length !== exp_res.length)
                        note_mismatch("Mismatch", exp_res, got);
                end
                n_results++;
            end
            if (i_s_tvalid && i_s_tready) begin
                req = t_list_request'(i_s_tdata[REQ_BITS-1:0]);
                expected_results.push_back(apply_list_request(req));
            end
            o_pending = expected_results.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import olirs_pkg::*;

    localparam int CAP     = CAPACITY_DEF;
    localparam int VAL_W   = VALUE_WIDTH_DEF;
    localparam int POS_W   = $clog2(CAP + 1);
    localparam int FOUND_W = $clog2(CAP) + 1;
    localparam int IN_W    = ((CMD_W + POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_W   = ((STATUS_W + FOUND_W + VAL_W + POS_W + 7) / 8) * 8;

    localparam int TOTAL_ITEMS     = 605;
    localparam int TAIL_START      = 545;
    localparam int HOLD_OFF_AT     = 200;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = CAP + 8;
    localparam int POOL_N          = 12;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               mismatches;
    int               pending;

    // stimulus bookkeeping: a rough length count only steers positions
    int               track_len;
    int               n_sent;
    int               n_full_tries;
    int               n_scans;
    int               gap_pct;
    int               idle_cycles;
    bit               tail_phase;
    bit               hold_off_req;
    bit               hold_off_active;
    logic [VAL_W-1:0] value_pool [POOL_N];

    ordered_list_insert_remove_search uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    list_checker #(.CAP(CAP), .VAL_W(VAL_W), .IN_W(IN_W), .OUT_W(OUT_W)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, one long hold-off, none near the end
    initial begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (hold_off_req && !hold_off_active) begin
                hold_off_active = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_active = 1'b0;
                hold_off_req    = 1'b0;
            end else if (!tail_phase && $urandom_range(0, 1) == 1) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        s_tdata  <= IN_W'({val, pos, cmd});
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_sent++;
        case (cmd)
            CMD_CLEAR:  track_len = 0;
            CMD_INSERT: begin
                if (track_len == CAP)
                    n_full_tries++;
                else if (pos <= track_len)
                    track_len++;
            end
            CMD_REMOVE: if (pos < track_len) track_len--;
            CMD_SEARCH, CMD_READ: n_scans++;
            default: ;
        endcase
        if (n_sent == HOLD_OFF_AT)
            hold_off_req = 1'b1;
        if (n_sent >= TAIL_START)
            tail_phase = 1'b1;
        if (!tail_phase && !hold_off_active && $urandom_range(1, 100) <= gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // mode 0 grows the list toward full, 1 drains it, 2 mixes everything
    task automatic send_random(input int mode);
        int               r;
        int               ins_w;
        int               rem_w;
        int               srch_w;
        int               clr_w;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        case (mode)
            0:       begin clr_w = 0; ins_w = 72; rem_w = 6;  srch_w = 11; end
            1:       begin clr_w = 1; ins_w = 15; rem_w = 50; srch_w = 17; end
            default: begin clr_w = 2; ins_w = 35; rem_w = 25; srch_w = 20; end
        endcase
        r = $urandom_range(0, 99);
        if (r < clr_w)                          cmd = CMD_CLEAR;
        else if (r < clr_w + ins_w)             cmd = CMD_INSERT;
        else if (r < clr_w + ins_w + rem_w)     cmd = CMD_REMOVE;
        else if (r < clr_w + ins_w + rem_w + srch_w) cmd = CMD_SEARCH;
        else                                    cmd = CMD_READ;

        if (cmd == CMD_INSERT && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, track_len));
        else if (cmd != CMD_INSERT && track_len > 0 && $urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(0, track_len - 1));
        else
            pos = POS_W'($urandom_range(0, CAP));

        // a small pool of values makes search hits and duplicates common
        if ($urandom_range(0, 99) < 70)
            val = value_pool[$urandom_range(0, POOL_N - 1)];
        else
            val = $urandom();
        send_request(cmd, pos, val);
    endtask

    initial begin
        int mode;
        int phase_len;
        int j;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        track_len       = 0;
        n_sent          = 0;
        n_full_tries    = 0;
        n_scans         = 0;
        gap_pct         = 25;
        idle_cycles     = 0;
        tail_phase      = 1'b0;
        hold_off_req    = 1'b0;
        hold_off_active = 1'b0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (j = 4; j < POOL_N; j++)
            value_pool[j] = $urandom();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corner cases
        send_request(CMD_READ,   0, 32'h0);
        send_request(CMD_REMOVE, 0, 32'h0);
        send_request(CMD_SEARCH, 0, 32'h0);
        send_request(CMD_INSERT, 1, 32'h1);
        // build: min, then max at the end, zero at the front, -1 in the middle
        send_request(CMD_INSERT, 0, 32'h8000_0000);
        send_request(CMD_INSERT, 1, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 0, 32'h0000_0000);
        send_request(CMD_INSERT, 1, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 0, 32'h7FFF_FFFF);
        send_request(CMD_SEARCH, 0, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 0, 32'h0000_3039);
        send_request(CMD_READ,   0, 32'h0);
        send_request(CMD_READ,   3, 32'h0);
        send_request(CMD_READ,   4, 32'h0);
        send_request(CMD_READ,   POS_W'(CAP), 32'h0);
        send_request(CMD_INSERT, POS_W'(CAP), 32'h5A5A_A5A5);
        send_request(CMD_REMOVE, 4, 32'h0);
        send_request(CMD_REMOVE, 3, 32'h0);
        send_request(CMD_REMOVE, 0, 32'h0);
        // unused command codes must leave the list alone
        send_request(CMD_W'(5), 0, 32'hFFFF_FFFF);
        send_request(CMD_W'(6), POS_W'(CAP), 32'h1234_5678);
        send_request(CMD_W'(7), 1, 32'h0);
        // duplicate: search must return the first position
        send_request(CMD_INSERT, 0, 32'hFFFF_FFFF);
        send_request(CMD_SEARCH, 0, 32'hFFFF_FFFF);
        send_request(CMD_CLEAR,  0, 32'h0);

        mode = 0;
        while (n_sent < TOTAL_ITEMS) begin
            phase_len = $urandom_range(40, 90);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            for (j = 0; j < phase_len && n_sent < TOTAL_ITEMS; j++)
                send_random(mode);
            mode = $urandom_range(0, 2);
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d list requests: %0d searches or reads, %0d inserts on a full list",
                 n_sent, n_scans, n_full_tries);
        $display("Mismatches: %0d, results never returned: %0d", mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
